[hdl/quadratic_newton_root_finder_core_assert.svh]
// ---------------------------------------------------------------------------
// assertion macros for the newton root finder
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_NEWTON_ROOT_FINDER_CORE_ASSERT_SVH
`define QUADRATIC_NEWTON_ROOT_FINDER_CORE_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define QNR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`endif

[hdl/qnr_pkg.sv]
// ---------------------------------------------------------------------------
// qnr_pkg
// types and codes shared by the newton root finder modules
// ---------------------------------------------------------------------------
package qnr_pkg;

  // result status codes
  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_ZERO_DER  = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_COEF_A   = 3'd0;
  localparam logic [2:0] REG_COEF_B   = 3'd1;
  localparam logic [2:0] REG_COEF_C   = 3'd2;
  localparam logic [2:0] REG_TOL      = 3'd3;
  localparam logic [2:0] REG_MAX_ITER = 3'd4;

  // serial arithmetic unit operations
  typedef enum logic [0:0] {
    OP_MUL,
    OP_DIV
  } op_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_AX,
    S_AXX,
    S_BX,
    S_SUMS,
    S_CHECK,
    S_DIV,
    S_UPDATE,
    S_DONE
  } state_t;

  // request bundle to the serial unit
  typedef struct packed {
    logic start;
    op_t  op;
  } arith_req_t;

endpackage

[hdl/quadratic_newton_root_finder_core.sv]
// ---------------------------------------------------------------------------
// quadratic_newton_root_finder_core
// newton iteration for a root of a*x*x+b*x+c in signed fixed point
// ---------------------------------------------------------------------------
// each newton step and the final evaluation run their products and quotient
//   through the one bit-serial unit
// throughput: one guess at a time; the next is taken once the result moves
// reset: synchronous; registers return to a=b=c=0, tolerance 1, limit 64
module quadratic_newton_root_finder_core #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [WORD_WIDTH-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [WORD_WIDTH-1:0]  initial_guess,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [WORD_WIDTH-1:0]  root,
  output logic [8:0]                    iterations,
  output logic [1:0]                    status
);
  import qnr_pkg::*;

  logic signed [WORD_WIDTH-1:0] coef_a, coef_b, coef_c;
  logic [15:0] tolerance;
  logic [7:0]  max_iterations;
  logic        seq_idle, seq_finish, start;
  logic signed [WORD_WIDTH-1:0] s_root;
  logic [8:0]  s_iter;
  logic [1:0]  s_status;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= '0; coef_b <= '0; coef_c <= '0;
      tolerance <= 16'd1; max_iterations <= 8'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COEF_A:   coef_a <= cfg_data;
        REG_COEF_B:   coef_b <= cfg_data;
        REG_COEF_C:   coef_c <= cfg_data;
        REG_TOL:      tolerance <= cfg_data[15:0];
        REG_MAX_ITER: max_iterations <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready = seq_idle && !out_valid;
  assign start    = in_valid && in_ready;

  qnr_sequencer #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_seq (
    .clk(clk), .rst(rst), .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .tolerance(tolerance), .max_iterations(max_iterations), .start(start),
    .guess(initial_guess), .idle(seq_idle), .finish(seq_finish),
    .root(s_root), .iterations(s_iter), .status(s_status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (seq_finish) begin
      out_valid <= 1'b1;
      root <= s_root; iterations <= s_iter; status <= s_status;
    end else if (out_ready) out_valid <= 1'b0;
  end

`include "quadratic_newton_root_finder_core_assert.svh"
  `QNR_ASSERT(a_no_start_busy, start |-> !out_valid)
  `QNR_ASSERT(a_iter_nonzero, out_valid |-> iterations != 9'd0)
  `QNR_ASSERT(a_finish_takes, seq_finish |=> out_valid)

endmodule

[hdl/qnr_serial_unit.sv]
// ---------------------------------------------------------------------------
// qnr_serial_unit
// bit-serial fixed-point multiply and divide with rounding toward zero
// and saturation to the word range
// ---------------------------------------------------------------------------
module qnr_serial_unit #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  qnr_pkg::arith_req_t           req,
  input  logic signed [WORD_WIDTH-1:0]  op_p,
  input  logic signed [WORD_WIDTH-1:0]  op_q,
  output logic                          busy,
  output logic                          done,
  output logic signed [WORD_WIDTH-1:0]  result,
  output logic                          ovf
);
  import qnr_pkg::*;

  localparam int PW = 2 * WORD_WIDTH;            // product / dividend width
  localparam int DW = WORD_WIDTH + FRAC_BITS;    // dividend bits used
  localparam int CW = $clog2(PW + 1);

  logic [WORD_WIDTH-1:0] mp;      // magnitude of p
  logic [WORD_WIDTH-1:0] mq;      // magnitude of q
  logic [PW-1:0]         acc;     // product accumulator or quotient shift
  logic [PW-1:0]         sh;      // shifting multiplicand or dividend
  logic [WORD_WIDTH:0]   rem;     // partial remainder
  logic [CW-1:0]         cnt;
  logic                  neg;
  op_t                   op;
  logic                  run;

  logic [WORD_WIDTH-1:0] abs_p, abs_q;
  logic [WORD_WIDTH:0]   rem_sh, rem_sub;
  logic [PW-1:0]         mag_res;
  logic [PW-1:0]         lim;
  logic                  big;

  assign abs_p = op_p[WORD_WIDTH-1] ? WORD_WIDTH'(-op_p) : WORD_WIDTH'(op_p);
  assign abs_q = op_q[WORD_WIDTH-1] ? WORD_WIDTH'(-op_q) : WORD_WIDTH'(op_q);

  // one restoring divide step
  assign rem_sh  = {rem[WORD_WIDTH-1:0], sh[PW-1]};
  assign rem_sub = rem_sh - {1'b0, mq};

  // iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !run) begin
        run <= 1'b1;
        op  <= req.op;
        neg <= op_p[WORD_WIDTH-1] ^ op_q[WORD_WIDTH-1];
        mp  <= abs_p;
        mq  <= abs_q;
        acc <= '0;
        rem <= '0;
        if (req.op == OP_MUL) begin
          sh  <= PW'(abs_q);
          cnt <= CW'(WORD_WIDTH);
        end else begin
          sh  <= PW'(abs_p) << (PW - DW + FRAC_BITS);
          cnt <= CW'(DW);
        end
      end else if (run) begin
        if (op == OP_MUL) begin
          // one multiplier bit a cycle, lsb first
          if (mp[0]) acc <= acc + sh;
          mp <= mp >> 1;
          sh <= sh << 1;
        end else begin
          // one quotient bit a cycle, msb first
          sh <= sh << 1;
          if (!rem_sub[WORD_WIDTH]) begin
            rem <= rem_sub;
            acc <= {acc[PW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            acc <= {acc[PW-2:0], 1'b0};
          end
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // scale, saturate and apply sign
  assign mag_res = (op == OP_MUL) ? (acc >> FRAC_BITS) : acc;
  assign lim     = neg ? (PW'(1) << (WORD_WIDTH - 1))
                       : ((PW'(1) << (WORD_WIDTH - 1)) - PW'(1));
  assign big     = mag_res > lim;
  assign ovf     = big;
  always_comb begin
    logic [PW-1:0] m;
    m = big ? lim : mag_res;
    result = neg ? WORD_WIDTH'(-m) : WORD_WIDTH'(m);
  end
  assign busy = run;

endmodule

[hdl/qnr_sequencer.sv]
// ---------------------------------------------------------------------------
// qnr_sequencer
// newton iteration control: evaluates f and f', tests stop cases and updates
// the estimate through the shared serial unit
// ---------------------------------------------------------------------------
module qnr_sequencer #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [WORD_WIDTH-1:0]  coef_a,
  input  logic signed [WORD_WIDTH-1:0]  coef_b,
  input  logic signed [WORD_WIDTH-1:0]  coef_c,
  input  logic [15:0]                   tolerance,
  input  logic [7:0]                    max_iterations,
  input  logic                          start,
  input  logic signed [WORD_WIDTH-1:0]  guess,
  output logic                          idle,
  output logic                          finish,
  output logic signed [WORD_WIDTH-1:0]  root,
  output logic [8:0]                    iterations,
  output logic [1:0]                    status
);
  import qnr_pkg::*;

  localparam logic signed [WORD_WIDTH-1:0] WMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic signed [WORD_WIDTH-1:0] WMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  state_t state, state_next;
  logic signed [WORD_WIDTH-1:0] estimate, func_value, deriv_value, ax, axx, bx;
  logic [8:0] step_count;
  logic       ovf;

  arith_req_t req;
  logic signed [WORD_WIDTH-1:0] op_p, op_q, u_res;
  logic u_busy, u_done, u_ovf;

  qnr_serial_unit #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_arith (
    .clk(clk), .rst(rst), .req(req), .op_p(op_p), .op_q(op_q),
    .busy(u_busy), .done(u_done), .result(u_res), .ovf(u_ovf)
  );

  // saturating add with overflow flag
  function automatic logic [WORD_WIDTH:0] sadd(
    input logic signed [WORD_WIDTH-1:0] p, input logic signed [WORD_WIDTH-1:0] q);
    logic signed [WORD_WIDTH:0] s;
    s = {p[WORD_WIDTH-1], p} + {q[WORD_WIDTH-1], q};
    if (s[WORD_WIDTH] != s[WORD_WIDTH-1])
      return {1'b1, s[WORD_WIDTH] ? WMIN : WMAX};
    return {1'b0, s[WORD_WIDTH-1:0]};
  endfunction

  // saturating subtract with overflow flag, exact for the most negative q
  function automatic logic [WORD_WIDTH:0] ssub(
    input logic signed [WORD_WIDTH-1:0] p, input logic signed [WORD_WIDTH-1:0] q);
    logic signed [WORD_WIDTH:0] s;
    s = {p[WORD_WIDTH-1], p} - {q[WORD_WIDTH-1], q};
    if (s[WORD_WIDTH] != s[WORD_WIDTH-1])
      return {1'b1, s[WORD_WIDTH] ? WMIN : WMAX};
    return {1'b0, s[WORD_WIDTH-1:0]};
  endfunction

  logic [WORD_WIDTH:0] s1, fsum, d1, dsum, upd;
  logic [WORD_WIDTH-1:0] fmag;
  logic conv, zder, lim;

  assign s1   = sadd(axx, bx);
  assign fsum = sadd(s1[WORD_WIDTH-1:0], coef_c);
  assign d1   = sadd(ax, ax);
  assign dsum = sadd(d1[WORD_WIDTH-1:0], coef_b);
  assign upd  = ssub(estimate, u_res);
  assign fmag = func_value[WORD_WIDTH-1] ? WORD_WIDTH'(-func_value)
                                         : WORD_WIDTH'(func_value);
  assign conv = fmag < WORD_WIDTH'(tolerance);
  assign zder = deriv_value == '0;
  assign lim  = step_count >= {1'b0, max_iterations};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_AX;
      S_AX:     if (u_done) state_next = S_AXX;
      S_AXX:    if (u_done) state_next = S_BX;
      S_BX:     if (u_done) state_next = S_SUMS;
      S_SUMS:   state_next = S_CHECK;
      S_CHECK:  state_next = (ovf || conv || zder || lim) ? S_DONE : S_DIV;
      S_DIV:    if (u_done) state_next = S_UPDATE;
      S_UPDATE: state_next = S_AX;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // serial unit requests
  always_comb begin
    req.start = 1'b0;
    req.op    = OP_MUL;
    op_p      = coef_a;
    op_q      = estimate;
    case (state)
      S_AX:  req.start = !u_busy && !u_done;
      S_AXX: begin req.start = !u_busy && !u_done; op_p = ax; end
      S_BX:  begin req.start = !u_busy && !u_done; op_p = coef_b; end
      S_DIV: begin
        req.start = !u_busy && !u_done; req.op = OP_DIV;
        op_p = func_value; op_q = deriv_value;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step_count <= '0;
      ovf <= 1'b0;
      estimate <= '0;
      func_value <= '0;
      deriv_value <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (start) begin
          estimate <= guess; ovf <= 1'b0; step_count <= '0;
        end
        S_AX:  if (u_done) begin ax <= u_res; ovf <= ovf | u_ovf; end
        S_AXX: if (u_done) begin axx <= u_res; ovf <= ovf | u_ovf; end
        S_BX:  if (u_done) begin bx <= u_res; ovf <= ovf | u_ovf; end
        S_SUMS: begin
          func_value  <= fsum[WORD_WIDTH-1:0];
          deriv_value <= dsum[WORD_WIDTH-1:0];
          ovf <= ovf | s1[WORD_WIDTH] | fsum[WORD_WIDTH] | d1[WORD_WIDTH]
                     | dsum[WORD_WIDTH];
        end
        S_CHECK: if (ovf || conv || zder || lim) begin
          root <= estimate;
          iterations <= step_count + 9'd1;
          status <= ovf ? ST_OVERFLOW : conv ? ST_CONVERGED
                  : zder ? ST_ZERO_DER : ST_LIMIT;
        end
        S_DIV: if (u_done) begin
          estimate <= upd[WORD_WIDTH-1:0];
          ovf <= ovf | u_ovf | upd[WORD_WIDTH];
        end
        S_UPDATE: step_count <= step_count + 9'd1;
        default: ;
      endcase
    end
  end

  assign idle   = state == S_IDLE;
  assign finish = state == S_DONE;

endmodule
